/* src/boot_page_region_allocator_top_assert.svh */
// Assertion macros for the boot page region allocator.
// Used by the top level; takes nothing else in.
`ifndef BOOT_PAGE_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define BOOT_PAGE_REGION_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define BPRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication under reset.
`define BPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BPRA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/bpra_pkg.sv */
// Shared types and constants of the boot page region allocator.
// Depends on nothing; used by the head unit and the top level.
package bpra_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_HOLE   = 2'd1,
        OP_FINISH = 2'd2,
        OP_ALLOC  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Work done on the region at the head of the ring.
    typedef enum logic [1:0] {
        HM_HOLE,
        HM_FINISH,
        HM_SELECT
    } t_head_mode;

    // What follows a selection pass.
    typedef enum logic [1:0] {
        AFT_FINISH,
        AFT_ALLOC_PRE,
        AFT_ALLOC_POST
    } t_after;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_HOLE,
        S_FINISH,
        S_SELECT,
        S_ALLOC,
        S_DONE
    } t_state;

    // Control outcome of the head unit.
    typedef struct packed {
        logic drop;
        logic split;
        logic better;
    } t_head_ctl;

    // Zone limits of the selection order.
    localparam logic [63:0] ZONE_LOW = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ZONE_MID = 64'h0000_0001_0000_0000;

endpackage

/* src/bpra_cell.sv */
// One slot position of the region ring: a base and a size register.
// Standalone; instantiated in a row by the top level.
module bpra_cell #(
    parameter int ADDR_BITS = 40
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic [ADDR_BITS-1:0] i_next_base,
    input  logic [ADDR_BITS-1:0] i_next_size,
    input  logic                 i_wr,
    input  logic [ADDR_BITS-1:0] i_wr_base,
    input  logic [ADDR_BITS-1:0] i_wr_size,
    output logic [ADDR_BITS-1:0] o_base,
    output logic [ADDR_BITS-1:0] o_size
);

    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_size;

    // A direct write wins over the hand-on from the neighbour.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_base <= i_wr_base;
            r_size <= i_wr_size;
        end else if (i_shift) begin
            r_base <= i_next_base;
            r_size <= i_next_size;
        end
    end

    assign o_base = r_base;
    assign o_size = r_size;

endmodule

/* src/bpra_head.sv */
// Head unit: processes the region leaving the ring head for hole, finish or selection.
// Depends on bpra_pkg.
module bpra_head #(
    parameter int ADDR_BITS  = 40,
    parameter int PAGE_BYTES = 4096
) (
    input  bpra_pkg::t_head_mode  i_mode,
    input  logic                  i_live,
    input  logic [ADDR_BITS-1:0]  i_base,
    input  logic [ADDR_BITS-1:0]  i_size,
    input  logic [ADDR_BITS-1:0]  i_hbase,
    input  logic [ADDR_BITS-1:0]  i_htop,
    input  logic                  i_best_found,
    input  logic [1:0]            i_best_zone,
    input  logic [ADDR_BITS-1:0]  i_best_size,
    output bpra_pkg::t_head_ctl   o_ctl,
    output logic [ADDR_BITS-1:0]  o_base,
    output logic [ADDR_BITS-1:0]  o_size,
    output logic [ADDR_BITS-1:0]  o_split_base,
    output logic [ADDR_BITS-1:0]  o_split_size,
    output logic [1:0]            o_zone
);

    localparam int AW = ADDR_BITS;
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [AW-1:0] PG      = AW'(PAGE_BYTES);
    localparam logic [AW-1:0] PG_MASK = ~AW'(PAGE_BYTES - 1);

    logic [AW:0]   w_top;
    logic [PB-1:0] w_adv;
    logic [AW:0]   w_alb;
    logic [AW-1:0] w_nsz;
    logic [63:0]   w_base64;

    // End of the region and alignment step of the base.
    assign w_top    = {1'b0, i_base} + {1'b0, i_size};
    assign w_adv    = PB'(0) - i_base[PB-1:0];
    assign w_alb    = {1'b0, i_base} + (AW+1)'(w_adv);
    assign w_nsz    = i_size - AW'(w_adv);
    assign w_base64 = 64'(i_base);

    // Address zone of the base.
    always_comb begin
        if (w_base64 < bpra_pkg::ZONE_LOW) begin
            o_zone = 2'd0;
        end else if (w_base64 < bpra_pkg::ZONE_MID) begin
            o_zone = 2'd1;
        end else begin
            o_zone = 2'd2;
        end
    end

    // Per-mode update of the head region.
    always_comb begin
        o_ctl        = '0;
        o_base       = i_base;
        o_size       = i_size;
        o_split_base = i_htop;
        o_split_size = AW'(w_top - {1'b0, i_htop});
        case (i_mode)
            bpra_pkg::HM_HOLE: begin
                if (i_live) begin
                    if (i_base >= i_hbase && w_top <= {1'b0, i_htop}) begin
                        o_ctl.drop = 1'b1;
                    end else if (i_base < i_hbase && w_top > {1'b0, i_htop}) begin
                        o_size      = i_hbase - i_base;
                        o_ctl.split = 1'b1;
                    end else if (i_base >= i_hbase && i_base < i_htop) begin
                        o_base = i_htop;
                        o_size = AW'(w_top - {1'b0, i_htop});
                    end else if (w_top > {1'b0, i_hbase} && w_top <= {1'b0, i_htop}) begin
                        o_size = i_hbase - i_base;
                    end
                end
            end
            bpra_pkg::HM_FINISH: begin
                if (i_live) begin
                    if (i_size < PG || w_alb[AW] || w_nsz < PG) begin
                        o_ctl.drop = 1'b1;
                    end else begin
                        o_base = w_alb[AW-1:0];
                        o_size = w_nsz & PG_MASK;
                    end
                end
            end
            default: begin
                if (i_live) begin
                    if (i_size < PG) begin
                        o_ctl.drop = 1'b1;
                    end else if (!i_best_found || o_zone > i_best_zone
                                 || (o_zone == i_best_zone && i_size > i_best_size)) begin
                        o_ctl.better = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

/* src/boot_page_region_allocator_top.sv */
// Top level of the boot page region allocator: ring of region cells, head unit, sequencer.
// Depends on bpra_pkg, bpra_cell, bpra_head and the assertion macro header.
//
//  channel | valid        | ready         | payload
//  in      | i_in_valid   | o_in_ready    | i_opcode, i_region_base, i_region_size
//  out     | o_out_valid  | i_out_ready   | o_page_addr, o_status
//
// An add and a plain alloc write one cell directly; a hole, a finish and an alloc that
// reselects make passes, and each pass rotates the cell ring once past the head unit.
// Reset is synchronous and clears only control state and valid bits; there is no clearing pass.
// One item is in work at a time; a finished result waits in the output register while
// the next beat is taken, and a stalled output holds the sequencer in its last state.
`include "boot_page_region_allocator_top_assert.svh"
module boot_page_region_allocator_top #(
    parameter int REGIONS    = 16,
    parameter int PAGE_BYTES = 4096,
    parameter int ADDR_BITS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [39:0] i_region_base,
    input  logic [39:0] i_region_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [39:0] o_page_addr,
    output logic [1:0]  o_status
);

    localparam int IW = $clog2(REGIONS);
    localparam int AW = ADDR_BITS;
    localparam logic [AW-1:0] PG        = AW'(PAGE_BYTES);
    localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}};
    localparam logic [IW-1:0] LAST      = IW'(REGIONS - 1);

    bpra_pkg::t_state  r_state, n_state;
    bpra_pkg::t_op     r_op;
    bpra_pkg::t_after  r_after;
    bpra_pkg::t_status r_status;
    logic [AW-1:0]     r_b, r_s, r_htop, r_page;
    logic [IW-1:0]     r_step;
    logic [REGIONS-1:0] r_visit, r_valid;
    logic [IW-1:0]     r_cur;
    logic              r_cur_valid;
    logic              r_found;
    logic [1:0]        r_best_zone;
    logic [AW-1:0]     r_best_size;
    logic [IW-1:0]     r_best_slot;
    logic              r_out_valid;
    logic [AW-1:0]     r_out_page;
    bpra_pkg::t_status r_out_status;

    logic [AW-1:0] w_cell_base [REGIONS];
    logic [AW-1:0] w_cell_size [REGIONS];
    logic          w_in_fire, w_out_free, w_shift, w_last, w_live;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_pos;
    logic [AW-1:0] w_wr_base, w_wr_size;
    logic          w_free_found;
    logic [IW-1:0] w_free_slot;
    logic [IW:0]   w_pos_raw;
    logic [IW-1:0] w_split_pos;
    logic [AW-1:0] w_in_base, w_in_size, w_add_size;
    logic [AW:0]   w_hsum;
    logic [AW-1:0] w_cur_base, w_cur_size, w_alloc_page, w_alloc_size;
    logic          w_cur_stale, w_sel_found;
    logic [IW-1:0] w_sel_slot;

    bpra_pkg::t_head_mode w_mode;
    bpra_pkg::t_head_ctl  w_ctl;
    logic [AW-1:0] w_h_base, w_h_size, w_h_split_base, w_h_split_size;
    logic [1:0]    w_h_zone;

    // Handshakes.
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == bpra_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_shift    = (r_state == bpra_pkg::S_HOLE) || (r_state == bpra_pkg::S_FINISH)
                        || (r_state == bpra_pkg::S_SELECT);
    assign w_last     = (r_step == LAST);

    // Input fields reduced to the address width.
    assign w_in_base  = AW'(i_region_base);
    assign w_in_size  = AW'(i_region_size);
    assign w_add_size = (r_s > ADDR_MASK - r_b) ? ADDR_MASK - r_b : r_s;
    assign w_hsum     = {1'b0, r_b} + {1'b0, r_s};

    // Lowest free slot.
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = REGIONS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = IW'(i);
            end
        end
    end

    // Ring position of the split target after this cycle's rotation.
    assign w_pos_raw   = {1'b0, w_free_slot} + (IW+1)'(REGIONS) - {1'b0, r_step}
                         - (IW+1)'(1);
    assign w_split_pos = (w_pos_raw >= (IW+1)'(REGIONS))
                         ? IW'(w_pos_raw - (IW+1)'(REGIONS)) : w_pos_raw[IW-1:0];

    // Current region, read with the ring at rest.
    assign w_cur_base   = w_cell_base[r_cur];
    assign w_cur_size   = w_cell_size[r_cur];
    assign w_cur_stale  = r_cur_valid && (!r_valid[r_cur] || w_cur_size < PG);
    assign w_alloc_page = w_cur_base + w_cur_size - PG;
    assign w_alloc_size = w_cur_size - PG;

    // Ring of cells: each takes its upper neighbour, the tail takes the head unit's result.
    for (genvar p = 0; p < REGIONS; p++) begin : g_cell
        logic [AW-1:0] w_nb, w_ns;
        if (p == REGIONS - 1) begin : g_tail
            assign w_nb = w_h_base;
            assign w_ns = w_h_size;
        end else begin : g_body
            assign w_nb = w_cell_base[p+1];
            assign w_ns = w_cell_size[p+1];
        end
        bpra_cell #(.ADDR_BITS(AW)) u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_next_base (w_nb),
            .i_next_size (w_ns),
            .i_wr        (w_wr_en && (w_wr_pos == IW'(p))),
            .i_wr_base   (w_wr_base),
            .i_wr_size   (w_wr_size),
            .o_base      (w_cell_base[p]),
            .o_size      (w_cell_size[p])
        );
    end

    // Head unit on ring position zero.
    always_comb begin
        case (r_state)
            bpra_pkg::S_HOLE:   w_mode = bpra_pkg::HM_HOLE;
            bpra_pkg::S_FINISH: w_mode = bpra_pkg::HM_FINISH;
            default:            w_mode = bpra_pkg::HM_SELECT;
        endcase
    end
    assign w_live = r_valid[r_step] && ((r_state != bpra_pkg::S_HOLE) || r_visit[r_step]);

    bpra_head #(.ADDR_BITS(AW), .PAGE_BYTES(PAGE_BYTES)) u_head (
        .i_mode       (w_mode),
        .i_live       (w_live),
        .i_base       (w_cell_base[0]),
        .i_size       (w_cell_size[0]),
        .i_hbase      (r_b),
        .i_htop       (r_htop),
        .i_best_found (r_found),
        .i_best_zone  (r_best_zone),
        .i_best_size  (r_best_size),
        .o_ctl        (w_ctl),
        .o_base       (w_h_base),
        .o_size       (w_h_size),
        .o_split_base (w_h_split_base),
        .o_split_size (w_h_split_size),
        .o_zone       (w_h_zone)
    );

    // Outcome of a selection pass including the last head.
    assign w_sel_found = r_found || w_ctl.better;
    assign w_sel_slot  = w_ctl.better ? r_step : r_best_slot;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpra_pkg::S_IDLE: begin
                if (w_in_fire) n_state = bpra_pkg::S_DISPATCH;
            end
            bpra_pkg::S_DISPATCH: begin
                unique case (r_op)
                    bpra_pkg::OP_ADD:    n_state = bpra_pkg::S_DONE;
                    bpra_pkg::OP_HOLE:   n_state = bpra_pkg::S_HOLE;
                    bpra_pkg::OP_FINISH: n_state = bpra_pkg::S_FINISH;
                    default: begin
                        n_state = w_cur_stale ? bpra_pkg::S_SELECT : bpra_pkg::S_ALLOC;
                    end
                endcase
            end
            bpra_pkg::S_HOLE: begin
                if (w_last) n_state = bpra_pkg::S_DONE;
            end
            bpra_pkg::S_FINISH: begin
                if (w_last) n_state = bpra_pkg::S_SELECT;
            end
            bpra_pkg::S_SELECT: begin
                if (w_last) begin
                    n_state = (r_after == bpra_pkg::AFT_ALLOC_PRE) ? bpra_pkg::S_ALLOC
                                                                   : bpra_pkg::S_DONE;
                end
            end
            bpra_pkg::S_ALLOC: begin
                n_state = (r_cur_valid && w_alloc_size < PG) ? bpra_pkg::S_SELECT
                                                             : bpra_pkg::S_DONE;
            end
            bpra_pkg::S_DONE: begin
                if (w_out_free) n_state = bpra_pkg::S_IDLE;
            end
            default: n_state = bpra_pkg::S_IDLE;
        endcase
    end

    // Direct cell write for add, split and alloc.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_pos  = w_free_slot;
        w_wr_base = r_b;
        w_wr_size = w_add_size;
        unique case (r_state)
            bpra_pkg::S_DISPATCH: begin
                w_wr_en = (r_op == bpra_pkg::OP_ADD) && w_free_found;
            end
            bpra_pkg::S_HOLE: begin
                w_wr_en   = w_ctl.split && w_free_found;
                w_wr_pos  = w_split_pos;
                w_wr_base = w_h_split_base;
                w_wr_size = w_h_split_size;
            end
            bpra_pkg::S_ALLOC: begin
                w_wr_en   = r_cur_valid;
                w_wr_pos  = r_cur;
                w_wr_base = w_cur_base;
                w_wr_size = w_alloc_size;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item registers (payload, no reset).
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op <= bpra_pkg::t_op'(i_opcode);
            r_b  <= w_in_base;
            r_s  <= w_in_size;
        end
        if (r_state == bpra_pkg::S_DISPATCH) begin
            r_htop <= w_hsum[AW] ? ADDR_MASK : w_hsum[AW-1:0];
        end
        if (r_state == bpra_pkg::S_SELECT && w_ctl.better) begin
            r_best_zone <= w_h_zone;
            r_best_size <= w_cell_size[0];
            r_best_slot <= r_step;
        end
    end

    // Control and table state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_valid     <= '0;
            r_visit     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_found     <= 1'b0;
            r_after     <= bpra_pkg::AFT_FINISH;
            r_status    <= bpra_pkg::ST_OK;
            r_page      <= '0;
        end else begin
            if (w_shift) begin
                r_step <= w_last ? '0 : r_step + IW'(1);
            end
            // Drops at the head release the slot; a selection pass sets the current region itself.
            if (w_shift && w_ctl.drop) begin
                r_valid[r_step] <= 1'b0;
                if (r_cur_valid && r_cur == r_step && r_state != bpra_pkg::S_SELECT) begin
                    r_cur_valid <= 1'b0;
                end
            end
            unique case (r_state)
                bpra_pkg::S_IDLE: begin
                    if (w_in_fire) begin
                        r_status <= bpra_pkg::ST_OK;
                        r_page   <= '0;
                        r_visit  <= r_valid;
                    end
                end
                bpra_pkg::S_DISPATCH: begin
                    r_found <= 1'b0;
                    if (r_op == bpra_pkg::OP_ADD) begin
                        if (w_free_found) r_valid[w_free_slot] <= 1'b1;
                        else r_status <= bpra_pkg::ST_FULL;
                    end
                    if (r_op == bpra_pkg::OP_FINISH) r_after <= bpra_pkg::AFT_FINISH;
                    if (r_op == bpra_pkg::OP_ALLOC) r_after <= bpra_pkg::AFT_ALLOC_PRE;
                end
                bpra_pkg::S_HOLE: begin
                    if (w_ctl.split) begin
                        if (w_free_found) r_valid[w_free_slot] <= 1'b1;
                        else r_status <= bpra_pkg::ST_FULL;
                    end
                end
                bpra_pkg::S_SELECT: begin
                    if (w_last) begin
                        r_cur_valid <= w_sel_found;
                        r_cur       <= w_sel_found ? w_sel_slot : '0;
                        r_found     <= 1'b0;
                        if (r_after == bpra_pkg::AFT_FINISH) begin
                            r_status <= w_sel_found ? bpra_pkg::ST_OK : bpra_pkg::ST_OOM;
                        end
                    end else if (w_ctl.better) begin
                        r_found <= 1'b1;
                    end
                end
                bpra_pkg::S_ALLOC: begin
                    r_after <= bpra_pkg::AFT_ALLOC_POST;
                    if (r_cur_valid) begin
                        r_page <= w_alloc_page;
                    end else begin
                        r_status <= bpra_pkg::ST_OOM;
                    end
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bpra_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bpra_pkg::S_DONE && w_out_free) begin
            r_out_page   <= r_page;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_page_addr = 40'(r_out_page);
    assign o_status    = r_out_status;

    // Checks.
    `BPRA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_fire, r_state == bpra_pkg::S_DISPATCH)
    `BPRA_ASSERT_NOW(a_ring_at_rest, i_clk, i_rst_n, !w_shift, r_step == '0)
    `BPRA_ASSERT_NOW(a_cur_is_valid, i_clk, i_rst_n, r_state == bpra_pkg::S_IDLE && r_cur_valid, r_valid[r_cur])
    `BPRA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, r_out_valid, r_out_status == bpra_pkg::ST_OK || r_out_status == bpra_pkg::ST_OOM || r_out_status == bpra_pkg::ST_FULL)

endmodule
